/* rtl/core/plbt_pkg.sv */
// ----------------------------------------------------------------------------
// Port label binding table package
// Shared codes, widths and the command record passed from front to back.
// ----------------------------------------------------------------------------
package plbt_pkg;

  localparam int unsigned DefTableEntries = 64;
  localparam int unsigned DefLabelBits    = 16;

  localparam int unsigned PortW    = 16;
  localparam int unsigned SockIdW  = 16;
  localparam int unsigned TypeW    = 4;
  localparam int unsigned LabelInW = 16;
  localparam int unsigned OpW      = 2;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned EntryIdxW = 6;

  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 16;

  // Depth of the command queue between front and back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [OpW-1:0] {
    OP_RELABEL = 2'd0,
    OP_BIND    = 2'd1,
    OP_MARK    = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    KIND_RELABEL,
    KIND_BIND,
    KIND_MARK,
    KIND_PORT_ZERO,
    KIND_NOP
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_RELABELED  = 3'd0,
    ST_NO_OWNER   = 3'd1,
    ST_PORT_ZERO  = 3'd2,
    ST_REUSED     = 3'd3,
    ST_REFUSED    = 3'd4,
    ST_INSERTED   = 3'd5,
    ST_FULL       = 3'd6,
    ST_MARKED     = 3'd7
  } status_e;

  typedef struct packed {
    kind_e               kind;
    logic [SockIdW-1:0]  socket_id;
    logic [PortW-1:0]    port;
    logic [TypeW-1:0]    socket_type;
    logic [LabelInW-1:0] label_in;
    logic [LabelInW-1:0] label_out;
  } cmd_t;

endpackage

/* rtl/core/plbt_front.sv */
// ----------------------------------------------------------------------------
// Port label binding table front end
// Accepts input transactions, unpacks and classifies them into commands.
// ----------------------------------------------------------------------------
module plbt_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [plbt_pkg::InDataW-1:0] in_data_i,
  output logic                         cmd_valid_o,
  input  logic                         cmd_ready_i,
  output plbt_pkg::cmd_t               cmd_o
);
  import plbt_pkg::*;

  logic       valid_q;
  cmd_t       cmd_q;
  cmd_t       cmd_d;
  logic [1:0] op;

  assign op = in_data_i[1:0];

  always_comb begin
    cmd_d.socket_id   = in_data_i[17:2];
    cmd_d.port        = in_data_i[33:18];
    cmd_d.socket_type = in_data_i[37:34];
    cmd_d.label_in    = in_data_i[53:38];
    cmd_d.label_out   = in_data_i[69:54];
    case (op)
      OP_RELABEL: cmd_d.kind = KIND_RELABEL;
      OP_MARK:    cmd_d.kind = KIND_MARK;
      OP_BIND: begin
        // A bind to port zero needs no table access.
        cmd_d.kind = (in_data_i[33:18] == '0) ? KIND_PORT_ZERO : KIND_BIND;
      end
      default:    cmd_d.kind = KIND_NOP;
    endcase
  end

  assign in_ready_o  = !valid_q || cmd_ready_i;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

/* rtl/core/plbt_queue.sv */
// ----------------------------------------------------------------------------
// Port label binding table command queue
// Short first-in first-out buffer of classified commands.
// ----------------------------------------------------------------------------
module plbt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  plbt_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output plbt_pkg::cmd_t pop_cmd_o
);
  import plbt_pkg::*;

  cmd_t                 slot_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q;
  logic [QueuePtrW-1:0] rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 push;
  logic                 pop;

  assign push_ready_o = (count_q != QueueCntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* rtl/core/plbt_back.sv */
// ----------------------------------------------------------------------------
// Port label binding table back end
// Scans the entry memory for one command, updates it and emits the result.
// ----------------------------------------------------------------------------
module plbt_back #(
  parameter int unsigned TABLE_ENTRIES = plbt_pkg::DefTableEntries,
  parameter int unsigned LABEL_BITS    = plbt_pkg::DefLabelBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_valid_i,
  output logic                            cmd_ready_o,
  input  plbt_pkg::cmd_t                  cmd_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [plbt_pkg::StatusW-1:0]    status_o,
  output logic [plbt_pkg::EntryIdxW-1:0]  entry_index_o
);
  import plbt_pkg::*;

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

  typedef struct packed {
    logic [PortW-1:0]      port;
    logic [TypeW-1:0]      socket_type;
    logic [SockIdW-1:0]    owner;
    logic [LABEL_BITS-1:0] label_in;
    logic [LABEL_BITS-1:0] label_out;
    logic                  reusable;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_e;

  // Entries are only ever inserted at the lowest free slot and never
  // removed, so the valid entries are exactly slots below the fill count.
  entry_t              mem [TABLE_ENTRIES];
  entry_t              rd_q;
  state_e              state_q;
  cmd_t                cmd_q;
  logic [CntW-1:0]     fill_q;
  logic [CntW-1:0]     issue_q;
  logic                rd_valid_q;
  logic [IdxW-1:0]     rd_idx_q;
  logic                hit_q;
  logic [IdxW-1:0]     hit_idx_q;
  entry_t              hit_entry_q;
  logic                out_valid_q;
  status_e             out_status_q;
  logic [EntryIdxW-1:0] out_index_q;

  logic                match;
  logic                more;
  logic                issue_en;
  logic                out_free;
  logic                wr_en;
  logic [IdxW-1:0]     wr_addr;
  entry_t              wr_data;
  logic                fill_inc;
  status_e             res_status;
  logic [EntryIdxW-1:0] res_index;

  assign more     = (issue_q < fill_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    if (cmd_q.kind == KIND_BIND) begin
      match = rd_valid_q && (rd_q.port == cmd_q.port)
              && (rd_q.socket_type == cmd_q.socket_type);
    end else begin
      match = rd_valid_q && (rd_q.owner == cmd_q.socket_id);
    end
  end

  assign issue_en = (state_q == S_SCAN) && !match && more;

  // Result and table update once the scan has settled.
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = hit_idx_q;
    wr_data    = hit_entry_q;
    fill_inc   = 1'b0;
    res_status = ST_NO_OWNER;
    res_index  = '0;
    case (cmd_q.kind)
      KIND_RELABEL: begin
        if (hit_q) begin
          wr_en             = 1'b1;
          wr_data.label_in  = LABEL_BITS'(cmd_q.label_in);
          wr_data.label_out = LABEL_BITS'(cmd_q.label_out);
          res_status        = ST_RELABELED;
          res_index         = EntryIdxW'(hit_idx_q);
        end
      end
      KIND_MARK: begin
        if (hit_q) begin
          wr_en            = 1'b1;
          wr_data.reusable = 1'b1;
          res_status       = ST_MARKED;
          res_index        = EntryIdxW'(hit_idx_q);
        end
      end
      KIND_BIND: begin
        if (hit_q) begin
          res_index = EntryIdxW'(hit_idx_q);
          if (hit_entry_q.reusable) begin
            wr_en             = 1'b1;
            wr_data.owner     = cmd_q.socket_id;
            wr_data.label_in  = LABEL_BITS'(cmd_q.label_in);
            wr_data.label_out = LABEL_BITS'(cmd_q.label_out);
            wr_data.reusable  = 1'b0;
            res_status        = ST_REUSED;
          end else begin
            res_status = ST_REFUSED;
          end
        end else if (fill_q == CntW'(TABLE_ENTRIES)) begin
          res_status = ST_FULL;
        end else begin
          wr_en               = 1'b1;
          wr_addr             = IdxW'(fill_q);
          wr_data.port        = cmd_q.port;
          wr_data.socket_type = cmd_q.socket_type;
          wr_data.owner       = cmd_q.socket_id;
          wr_data.label_in    = LABEL_BITS'(cmd_q.label_in);
          wr_data.label_out   = LABEL_BITS'(cmd_q.label_out);
          wr_data.reusable    = 1'b0;
          fill_inc            = 1'b1;
          res_status          = ST_INSERTED;
          res_index           = EntryIdxW'(fill_q);
        end
      end
      KIND_PORT_ZERO: res_status = ST_PORT_ZERO;
      default:        res_status = ST_NO_OWNER;
    endcase
  end

  assign cmd_ready_o   = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign entry_index_o = out_index_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fill_q       <= '0;
      issue_q      <= '0;
      rd_valid_q   <= 1'b0;
      hit_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      rd_idx_q     <= '0;
      hit_idx_q    <= '0;
      out_status_q <= ST_RELABELED;
      out_index_q  <= '0;
    end else begin
      // In the apply state the result register is reloaded below instead.
      if (out_valid_q && out_ready_i && (state_q != S_APPLY)) begin
        out_valid_q <= 1'b0;
      end
      rd_valid_q <= issue_en;
      if (issue_en) begin
        rd_idx_q <= issue_q[IdxW-1:0];
        issue_q  <= issue_q + 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            hit_q   <= 1'b0;
            issue_q <= '0;
            if (cmd_i.kind == KIND_PORT_ZERO || cmd_i.kind == KIND_NOP) begin
              state_q <= S_APPLY;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (match) begin
            hit_q     <= 1'b1;
            hit_idx_q <= rd_idx_q;
            state_q   <= S_APPLY;
          end else if (!rd_valid_q && !more) begin
            state_q <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status;
            out_index_q  <= res_index;
            if (fill_inc) begin
              fill_q <= fill_q + 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_valid_i) begin
      cmd_q <= cmd_i;
    end
    if (state_q == S_SCAN && match) begin
      hit_entry_q <= rd_q;
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (state_q == S_APPLY && out_free && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue_en) begin
      rd_q <= mem[issue_q[IdxW-1:0]];
    end
  end

endmodule

/* rtl/core/port_label_binding_table.sv */
// ----------------------------------------------------------------------------
// Port label binding table
// Table of port bindings with socket owners and labels, driven by a stream.
// ----------------------------------------------------------------------------
// Each input transaction carries one operation (relabel, bind or mark
// reusable) and produces exactly one output transaction with a status code
// and the slot it touched. A front stage unpacks and classifies the
// operation and hands it through a two-entry queue to a back end that owns
// the entry memory. The back end searches the valid entries in slot order
// through the single registered read port of that memory, one entry per
// cycle, and stops at the first match, so the lowest matching slot always
// wins. Entries are only ever added at the lowest free slot and never
// removed, which lets a fill count stand in for per-entry valid bits; no
// clearing pass is needed after reset. In the back end an operation goes
// from the idle state through the scan state to the apply state; a bind
// to port zero or an unused operation code goes from idle straight to
// apply without a search. The output register lets the next operation
// be taken and searched while a finished result still waits on m_axis_tready.
// ----------------------------------------------------------------------------
module port_label_binding_table #(
  parameter int unsigned TABLE_ENTRIES = plbt_pkg::DefTableEntries,
  parameter int unsigned LABEL_BITS    = plbt_pkg::DefLabelBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Operation stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0 up: op[2], socket_id[16], port[16], socket_type[4],
  // label_in[16], label_out[16], two zero bits.
  input  logic [plbt_pkg::InDataW-1:0]  s_axis_tdata,
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0 up: status[3], entry_index[6], seven zero bits.
  output logic [plbt_pkg::OutDataW-1:0] m_axis_tdata
);
  import plbt_pkg::*;

  logic                 front_valid;
  logic                 front_ready;
  cmd_t                 front_cmd;
  logic                 back_valid;
  logic                 back_ready;
  cmd_t                 back_cmd;
  logic [StatusW-1:0]   status;
  logic [EntryIdxW-1:0] entry_index;

  // Classify incoming operations.
  plbt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  // Decouple the front from the table search.
  plbt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_cmd_o    (back_cmd)
  );

  // Search, update and answer.
  plbt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .LABEL_BITS    (LABEL_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (back_valid),
    .cmd_ready_o   (back_ready),
    .cmd_i         (back_cmd),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .status_o      (status),
    .entry_index_o (entry_index)
  );

  assign m_axis_tdata = {{(OutDataW - StatusW - EntryIdxW){1'b0}}, entry_index, status};

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Port label binding table testbench
// A stream driver and a response monitor run the table against a behavioral
// copy of its entries and check the status and slot of every result.
// ----------------------------------------------------------------------------
module tb_top;
  import plbt_pkg::*;

  // The table is never shrunk, so the sizes here follow the defaults that
  // the block is built with.
  localparam int unsigned TableEntries = DefTableEntries;
  localparam int unsigned RandomItems  = 1250;
  localparam int unsigned DrainCycles  = 2 * DefTableEntries + 20;
  localparam int unsigned CycleLimit   = 1000000;

  // Operation code 3 has no member in op_e. The block must answer it as a
  // miss without touching the table.
  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

  // One operation as it is presented on the input stream, together with the
  // idle phase under which it is to be driven.
  typedef struct {
    logic [OpW-1:0]      op;
    logic [SockIdW-1:0]  socket_id;
    logic [PortW-1:0]    port;
    logic [TypeW-1:0]    socket_type;
    logic [LabelInW-1:0] label_in;
    logic [LabelInW-1:0] label_out;
    int unsigned         phase;
  } table_op_t;

  typedef struct {
    status_e              status;
    logic [EntryIdxW-1:0] slot;
  } table_result_t;

  // A binding that the stimulus has asked for, kept so that later items can
  // mark its owner and then bind the same port and type again.
  typedef struct {
    logic [PortW-1:0]   port;
    logic [TypeW-1:0]   socket_type;
    logic [SockIdW-1:0] socket_id;
  } binding_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_data = '0;
  logic                m_axis_tvalid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  port_label_binding_table DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    // Fields from bit 0 up: op[2], socket_id[16], port[16], socket_type[4],
    // label_in[16], label_out[16], two zero bits.
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    // Fields from bit 0 up: status[3], entry_index[6], seven zero bits.
    .m_axis_tdata  (m_axis_tdata)
  );

  // Shadow of the binding table. Only valid slots are ever read, so the
  // other arrays need no reset.
  bit                  slot_valid     [TableEntries];
  logic [PortW-1:0]    slot_port      [TableEntries];
  logic [TypeW-1:0]    slot_type      [TableEntries];
  logic [SockIdW-1:0]  slot_owner     [TableEntries];
  logic [LabelInW-1:0] slot_label_in  [TableEntries];
  logic [LabelInW-1:0] slot_label_out [TableEntries];
  bit                  slot_reusable  [TableEntries];

  table_op_t     pending_ops[$];
  table_result_t expected_results[$];
  table_op_t     driven_op;
  table_result_t oldest_result;
  bit            op_taken = 1'b0;
  int unsigned   rx_idle_pct = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   result_count = 0;
  int unsigned   cycle_count = 0;

  // Free-running 10 ns clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Applies one operation to the shadow table and returns the answer that
  // the block has to give for it. Every search picks the lowest matching slot.
  function automatic table_result_t apply_table_op(table_op_t t);
    table_result_t r;
    int hit;
    int free_slot;
    r.status  = ST_NO_OWNER;
    r.slot    = '0;
    hit       = -1;
    free_slot = -1;
    case (t.op)
      OP_RELABEL, OP_MARK: begin
        for (int i = 0; i < TableEntries; i++) begin
          if (hit < 0 && slot_valid[i] && slot_owner[i] == t.socket_id) hit = i;
        end
        if (hit >= 0) begin
          r.slot = EntryIdxW'(hit);
          if (t.op == OP_RELABEL) begin
            slot_label_in[hit]  = t.label_in;
            slot_label_out[hit] = t.label_out;
            r.status = ST_RELABELED;
          end else begin
            slot_reusable[hit] = 1'b1;
            r.status = ST_MARKED;
          end
        end
      end
      OP_BIND: begin
        if (t.port == '0) begin
          r.status = ST_PORT_ZERO;
        end else begin
          for (int i = 0; i < TableEntries; i++) begin
            if (hit < 0 && slot_valid[i] && slot_port[i] == t.port &&
                slot_type[i] == t.socket_type) hit = i;
            if (free_slot < 0 && !slot_valid[i]) free_slot = i;
          end
          if (hit >= 0) begin
            r.slot = EntryIdxW'(hit);
            if (!slot_reusable[hit]) begin
              r.status = ST_REFUSED;
            end else begin
              // A takeover keeps port and type, which already match.
              slot_owner[hit]     = t.socket_id;
              slot_label_in[hit]  = t.label_in;
              slot_label_out[hit] = t.label_out;
              slot_reusable[hit]  = 1'b0;
              r.status = ST_REUSED;
            end
          end else if (free_slot >= 0) begin
            slot_valid[free_slot]     = 1'b1;
            slot_port[free_slot]      = t.port;
            slot_type[free_slot]      = t.socket_type;
            slot_owner[free_slot]     = t.socket_id;
            slot_label_in[free_slot]  = t.label_in;
            slot_label_out[free_slot] = t.label_out;
            slot_reusable[free_slot]  = 1'b0;
            r.status = ST_INSERTED;
            r.slot   = EntryIdxW'(free_slot);
          end else begin
            r.status = ST_FULL;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_op(input logic [OpW-1:0] op, input logic [SockIdW-1:0] sid,
                          input logic [PortW-1:0] port, input logic [TypeW-1:0] stype,
                          input logic [LabelInW-1:0] lin, input logic [LabelInW-1:0] lout,
                          input int unsigned ph);
    table_op_t t;
    t.op          = op;
    t.socket_id   = sid;
    t.port        = port;
    t.socket_type = stype;
    t.label_in    = lin;
    t.label_out   = lout;
    t.phase       = ph;
    pending_ops.push_back(t);
  endtask

  // Mostly a small pool of sockets so that owners repeat, now and then any
  // value so that every bit of the identifier is exercised.
  function automatic logic [SockIdW-1:0] pick_socket();
    if ($urandom_range(99) < 90) return SockIdW'($urandom_range(31));
    return SockIdW'($urandom);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch in result %0d: %s is %0d, expected %0d",
             result_count, what, got, want);
    mismatch_count++;
  endtask

  // Idle phases: none, sender idle, receiver stalling, both.
  function automatic int unsigned pending_tx_idle(int unsigned ph);
    return (ph == 1) ? 77 : (ph == 3) ? 32 : 0;
  endfunction

  function automatic int unsigned pending_rx_idle(int unsigned ph);
    return (ph == 2) ? 77 : (ph == 3) ? 32 : 0;
  endfunction

  // Input side, sampled at the rising edge: a transaction that completes here
  // is run through the shadow table and its answer is queued.
  always @(posedge clk_i) begin
    if (rst_ni && s_valid && s_axis_tready) begin
      expected_results.push_back(apply_table_op(driven_op));
      op_taken <= 1'b1;
    end else begin
      op_taken <= 1'b0;
    end
  end

  // Driver. It changes the stream at the falling edge, either moving on to
  // the next pending operation or holding off at random with valid low.
  // The valid line gets at most one assignment per edge.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_valid || op_taken)) begin
      if (pending_ops.size() != 0 &&
          $urandom_range(99) >= pending_tx_idle(pending_ops[0].phase)) begin
        driven_op   <= pending_ops[0];
        s_data      <= {2'b00, pending_ops[0].label_out, pending_ops[0].label_in,
                        pending_ops[0].socket_type, pending_ops[0].port,
                        pending_ops[0].socket_id, pending_ops[0].op};
        rx_idle_pct <= pending_rx_idle(pending_ops[0].phase);
        s_valid     <= 1'b1;
        void'(pending_ops.pop_front());
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // The receiver stalls at random, following the phase of the operation
  // most recently driven.
  always @(negedge clk_i) begin
    if (rst_ni) m_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Monitor. Each result transaction is held against the oldest answer that
  // the shadow table has produced; the padding bits have to stay zero.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, status", m_axis_tdata[2:0], 0);
      end else begin
        oldest_result = expected_results.pop_front();
        if (m_axis_tdata[2:0] !== oldest_result.status)
          report_mismatch("status", m_axis_tdata[2:0], oldest_result.status);
        if (m_axis_tdata[8:3] !== oldest_result.slot)
          report_mismatch("entry_index", m_axis_tdata[8:3], oldest_result.slot);
        if (m_axis_tdata[OutDataW-1:9] !== '0)
          report_mismatch("padding", m_axis_tdata[OutDataW-1:9], 0);
      end
      result_count++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("port_label_binding_table test failed");
      $finish;
    end
  end

  initial begin
    binding_t           bindings_seen[$];
    binding_t           b;
    int unsigned        counted;
    int unsigned        ph;
    int unsigned        roll;
    logic [SockIdW-1:0] sid;
    logic [PortW-1:0]   port;
    logic [TypeW-1:0]   stype;

    // Directed opening: misses on the empty table, the unused code, port
    // zero, extreme fields, a refused bind, lowest-slot wins among several
    // owned entries, and a mark followed by a takeover.
    queue_op(OP_RELABEL, 16'h0000, 16'h0000, 4'h0, 16'h0000, 16'h0000, 0);
    queue_op(OP_MARK,    16'hFFFF, 16'hFFFF, 4'hF, 16'hFFFF, 16'hFFFF, 0);
    queue_op(OP_UNUSED,  16'h1234, 16'h0040, 4'h3, 16'h5555, 16'hAAAA, 0);
    queue_op(OP_BIND,    16'hFFFF, 16'h0000, 4'hF, 16'hFFFF, 16'hFFFF, 0);
    queue_op(OP_BIND,    16'hFFFF, 16'hFFFF, 4'hF, 16'hFFFF, 16'hFFFF, 0);
    queue_op(OP_BIND,    16'h0000, 16'h0001, 4'h0, 16'h0000, 16'h0000, 0);
    queue_op(OP_BIND,    16'h0005, 16'hFFFF, 4'hF, 16'h1111, 16'h2222, 0);
    queue_op(OP_BIND,    16'hFFFF, 16'hFFFF, 4'h0, 16'h3333, 16'h4444, 0);
    queue_op(OP_RELABEL, 16'hFFFF, 16'h0000, 4'h0, 16'hAAAA, 16'h5555, 0);
    queue_op(OP_MARK,    16'hFFFF, 16'h0000, 4'h0, 16'h0000, 16'h0000, 0);
    queue_op(OP_BIND,    16'h0007, 16'hFFFF, 4'hF, 16'h0F0F, 16'hF0F0, 0);
    queue_op(OP_BIND,    16'h0008, 16'hFFFF, 4'hF, 16'h0000, 16'h0000, 0);
    queue_op(OP_RELABEL, 16'hFFFF, 16'h8000, 4'h8, 16'h8000, 16'h8000, 0);
    queue_op(OP_MARK,    16'h0007, 16'h0000, 4'h0, 16'h0000, 16'h0000, 0);
    queue_op(OP_RELABEL, 16'h0007, 16'h0000, 4'h0, 16'h7FFF, 16'h7FFF, 0);
    queue_op(OP_BIND,    16'h0009, 16'hFFFF, 4'hF, 16'hFFFF, 16'h0000, 0);
    queue_op(OP_UNUSED,  16'hFFFF, 16'hFFFF, 4'hF, 16'hFFFF, 16'hFFFF, 0);
    queue_op(OP_RELABEL, 16'h0000, 16'hFFFF, 4'hF, 16'hFFFF, 16'hFFFF, 0);
    queue_op(OP_MARK,    16'h0000, 16'h0001, 4'h0, 16'h0000, 16'h0000, 0);
    queue_op(OP_BIND,    16'h0000, 16'h0001, 4'h0, 16'h0001, 16'h0002, 0);

    // Random part. The ports and types come from a narrow pool so the table
    // fills up and binds collide; a good share of the items are mark-then-bind
    // pairs aimed at an earlier binding, to bring about takeovers.
    counted = 0;
    while (counted < RandomItems) begin
      ph   = counted * 4 / RandomItems;
      roll = $urandom_range(99);
      sid  = pick_socket();
      if (roll < 30 && bindings_seen.size() != 0) begin
        b = bindings_seen[$urandom_range(bindings_seen.size() - 1)];
        queue_op(OP_MARK, b.socket_id, PortW'($urandom), TypeW'($urandom),
                 LabelInW'($urandom), LabelInW'($urandom), ph);
        queue_op(OP_BIND, sid, b.port, b.socket_type,
                 LabelInW'($urandom), LabelInW'($urandom), ph);
        b.socket_id = sid;
        bindings_seen.push_back(b);
        counted += 2;
      end else if (roll < 65) begin
        roll  = $urandom_range(99);
        port  = (roll < 4) ? '0 : (roll < 14) ? PortW'($urandom) :
                PortW'($urandom_range(48, 1));
        stype = ($urandom_range(99) < 85) ? TypeW'($urandom_range(3)) :
                TypeW'($urandom_range(15));
        queue_op(OP_BIND, sid, port, stype, LabelInW'($urandom), LabelInW'($urandom), ph);
        if (port != '0) begin
          b.port        = port;
          b.socket_type = stype;
          b.socket_id   = sid;
          bindings_seen.push_back(b);
          counted++;
        end
      end else if (roll < 85) begin
        queue_op(OP_RELABEL, sid, PortW'($urandom), TypeW'($urandom),
                 LabelInW'($urandom), LabelInW'($urandom), ph);
        counted++;
      end else if (roll < 95) begin
        queue_op(OP_MARK, sid, PortW'($urandom), TypeW'($urandom),
                 LabelInW'($urandom), LabelInW'($urandom), ph);
        counted++;
      end else begin
        // The unused code leaves the table untouched and does not count.
        queue_op(OP_UNUSED, SockIdW'($urandom), PortW'($urandom), TypeW'($urandom),
                 LabelInW'($urandom), LabelInW'($urandom), ph);
      end
    end

    // Reset is released on a falling edge.
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for the last operation to be taken and its answer to come back,
    // then leave room for the longest search so any stray result shows up.
    while (pending_ops.size() != 0 || s_valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("port_label_binding_table test passed");
    end else begin
      $display("port_label_binding_table test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/plbt_pkg.sv
rtl/core/plbt_front.sv
rtl/core/plbt_queue.sv
rtl/core/plbt_back.sv
rtl/core/port_label_binding_table.sv
test/tb_top.sv
